### src/vau_pkg.sv
// ============================================================================
// vau_pkg
// Shared types, opcodes and constants of the three-component vector unit.
// ============================================================================
package vau_pkg;

    // Default number of fractional bits of the fixed-point format.
    localparam int VAU_FRAC_BITS = 16;

    // Result bits of the square root, one per pipeline step.
    localparam int VAU_SQRT_STEPS = 32;

    // Saturation limits of a 32-bit signed result.
    localparam logic signed [31:0] VAU_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAU_MIN = 32'sh8000_0000;

    // Operation codes.
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_ADD_S = 4'd2;
    localparam logic [3:0] OP_SUB_S = 4'd3;
    localparam logic [3:0] OP_MUL_S = 4'd4;
    localparam logic [3:0] OP_DIV_S = 4'd5;
    localparam logic [3:0] OP_DOT   = 4'd6;
    localparam logic [3:0] OP_CROSS = 4'd7;
    localparam logic [3:0] OP_MAG   = 4'd8;
    localparam logic [3:0] OP_NORM  = 4'd9;
    localparam logic [3:0] OP_EQ    = 4'd10;
    localparam logic [3:0] OP_GT    = 4'd11;
    localparam logic [3:0] OP_LT    = 4'd12;

    // Request transaction.
    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scalar_in;
    } vau_req_t;

    // Result transaction.
    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar_out;
        logic               flag_out;
        logic               error_out;
    } vau_rsp_t;

    // Item data that travels with the root and divider pipelines.
    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] s;
        vau_rsp_t           early;
    } vau_side_t;

endpackage

### src/vau_front.sv
// ============================================================================
// vau_front
// Four-stage front end: input register, multipliers, product sums, rounding
// and saturation. Produces final results for all operations that need no
// root or quotient, and the sum of squares of vector a.
// ============================================================================
module vau_front #(
    parameter int FRAC_BITS = vau_pkg::VAU_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  vau_pkg::vau_req_t   req,
    output logic                out_valid,
    output vau_pkg::vau_side_t  side,
    output logic [63:0]         ssq
);
    import vau_pkg::*;

    localparam logic signed [66:0] RND_HALF = 67'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [66:0] SAT_HI   = 67'sd2147483647;
    localparam logic signed [66:0] SAT_LO   = -67'sd2147483648;

    // Round to nearest (ties up), scale down and saturate; msb is the error.
    function automatic logic [32:0] rnd_sat(input logic signed [66:0] v);
        logic signed [66:0] t;
        logic signed [66:0] q;
        logic [32:0]        res;
        t = v + RND_HALF;
        q = t >>> FRAC_BITS;
        if (q > SAT_HI)
            res = {1'b1, VAU_MAX};
        else if (q < SAT_LO)
            res = {1'b1, VAU_MIN};
        else
            res = {1'b0, q[31:0]};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    logic     v1_reg;
    vau_req_t req1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        req1_reg <= req;
    end

    // ------------------------------------------------------------------
    // Stage 2: operand selection, six multipliers, add and subtract.
    // ------------------------------------------------------------------
    logic signed [31:0] a1 [0:2];
    logic signed [31:0] b1 [0:2];
    logic signed [31:0] ma [0:5];
    logic signed [31:0] mb [0:5];
    logic signed [31:0] as_next [0:2];
    logic [2:0]         ase_next;
    logic signed [32:0] sum33;
    logic signed [31:0] opnd;
    logic               sub;

    always_comb
    begin
        a1[0] = req1_reg.a_x;
        a1[1] = req1_reg.a_y;
        a1[2] = req1_reg.a_z;
        b1[0] = req1_reg.b_x;
        b1[1] = req1_reg.b_y;
        b1[2] = req1_reg.b_z;
        // Default pairing gives the squares of a and of b.
        for (int i = 0; i < 3; i++)
        begin
            ma[i]     = a1[i];
            mb[i]     = a1[i];
            ma[i + 3] = b1[i];
            mb[i + 3] = b1[i];
        end
        case (req1_reg.req_type)
            OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                    mb[i] = b1[i];
            end
            OP_MUL_S:
            begin
                for (int i = 0; i < 3; i++)
                    mb[i] = req1_reg.scalar_in;
            end
            OP_CROSS:
            begin
                ma[0] = a1[1]; mb[0] = b1[2];
                ma[1] = a1[2]; mb[1] = b1[1];
                ma[2] = a1[2]; mb[2] = b1[0];
                ma[3] = a1[0]; mb[3] = b1[2];
                ma[4] = a1[0]; mb[4] = b1[1];
                ma[5] = a1[1]; mb[5] = b1[0];
            end
            default:
            begin
            end
        endcase
    end

    // Element-wise add or subtract with saturation.
    always_comb
    begin
        sub  = (req1_reg.req_type == OP_SUB) || (req1_reg.req_type == OP_SUB_S);
        sum33 = '0;
        opnd  = '0;
        for (int i = 0; i < 3; i++)
        begin
            opnd = ((req1_reg.req_type == OP_ADD) || (req1_reg.req_type == OP_SUB)) ?
                   b1[i] : req1_reg.scalar_in;
            sum33 = sub ? (33'(a1[i]) - 33'(opnd)) : (33'(a1[i]) + 33'(opnd));
            ase_next[i] = sum33[32] ^ sum33[31];
            as_next[i]  = (sum33[32] ^ sum33[31]) ? (sum33[32] ? VAU_MIN : VAU_MAX) :
                          sum33[31:0];
        end
    end

    logic               v2_reg;
    logic [3:0]         op2_reg;
    logic signed [31:0] a2_reg [0:2];
    logic signed [31:0] s2_reg;
    logic signed [63:0] p2_reg [0:5];
    logic signed [31:0] as2_reg [0:2];
    logic [2:0]         ase2_reg;
    logic               eq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        op2_reg  <= req1_reg.req_type;
        s2_reg   <= req1_reg.scalar_in;
        ase2_reg <= ase_next;
        eq2_reg  <= (a1[0] == b1[0]) && (a1[1] == b1[1]) && (a1[2] == b1[2]);
        for (int i = 0; i < 3; i++)
        begin
            a2_reg[i]  <= a1[i];
            as2_reg[i] <= as_next[i];
        end
        for (int j = 0; j < 6; j++)
            p2_reg[j] <= 64'(ma[j]) * 64'(mb[j]);
    end

    // ------------------------------------------------------------------
    // Stage 3: exact sums of products.
    // ------------------------------------------------------------------
    logic               v3_reg;
    logic [3:0]         op3_reg;
    logic signed [31:0] a3_reg [0:2];
    logic signed [31:0] s3_reg;
    logic signed [31:0] as3_reg [0:2];
    logic [2:0]         ase3_reg;
    logic               eq3_reg;
    logic signed [65:0] sum012_reg;
    logic signed [65:0] sum345_reg;
    logic signed [64:0] cr3_reg [0:2];
    logic signed [63:0] pm3_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        op3_reg    <= op2_reg;
        s3_reg     <= s2_reg;
        ase3_reg   <= ase2_reg;
        eq3_reg    <= eq2_reg;
        sum012_reg <= 66'(p2_reg[0]) + 66'(p2_reg[1]) + 66'(p2_reg[2]);
        sum345_reg <= 66'(p2_reg[3]) + 66'(p2_reg[4]) + 66'(p2_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            a3_reg[i]  <= a2_reg[i];
            as3_reg[i] <= as2_reg[i];
            pm3_reg[i] <= p2_reg[i];
            cr3_reg[i] <= 65'(p2_reg[2 * i]) - 65'(p2_reg[2 * i + 1]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rounding, saturation, compares and result assembly.
    // ------------------------------------------------------------------
    logic [32:0] rm [0:2];
    logic [32:0] rc [0:2];
    logic [32:0] rd;
    vau_side_t   side_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rm[i] = rnd_sat(67'(pm3_reg[i]));
            rc[i] = rnd_sat(67'(cr3_reg[i]));
        end
        rd = rnd_sat(67'(sum012_reg));

        side_next       = '0;
        side_next.op    = op3_reg;
        side_next.a_x   = a3_reg[0];
        side_next.a_y   = a3_reg[1];
        side_next.a_z   = a3_reg[2];
        side_next.s     = s3_reg;
        case (op3_reg)
            OP_ADD, OP_SUB, OP_ADD_S, OP_SUB_S:
            begin
                side_next.early.r_x       = as3_reg[0];
                side_next.early.r_y       = as3_reg[1];
                side_next.early.r_z       = as3_reg[2];
                side_next.early.error_out = |ase3_reg;
            end
            OP_MUL_S:
            begin
                side_next.early.r_x       = rm[0][31:0];
                side_next.early.r_y       = rm[1][31:0];
                side_next.early.r_z       = rm[2][31:0];
                side_next.early.error_out = rm[0][32] | rm[1][32] | rm[2][32];
            end
            OP_DIV_S:
            begin
                // Marks a zero divisor for the output stage.
                side_next.early.error_out = (s3_reg == '0);
            end
            OP_DOT:
            begin
                side_next.early.scalar_out = rd[31:0];
                side_next.early.error_out  = rd[32];
            end
            OP_CROSS:
            begin
                side_next.early.r_x       = rc[0][31:0];
                side_next.early.r_y       = rc[1][31:0];
                side_next.early.r_z       = rc[2][31:0];
                side_next.early.error_out = rc[0][32] | rc[1][32] | rc[2][32];
            end
            OP_EQ:
            begin
                side_next.early.flag_out = eq3_reg;
            end
            OP_GT:
            begin
                side_next.early.flag_out = sum012_reg > sum345_reg;
            end
            OP_LT:
            begin
                side_next.early.flag_out = sum012_reg < sum345_reg;
            end
            default:
            begin
            end
        endcase
    end

    logic        v4_reg;
    vau_side_t   side4_reg;
    logic [63:0] ssq4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        side4_reg <= side_next;
        ssq4_reg  <= sum012_reg[63:0];
    end

    assign out_valid = v4_reg;
    assign side      = side4_reg;
    assign ssq       = ssq4_reg;

endmodule

### src/vau_sqrt.sv
// ============================================================================
// vau_sqrt
// Pipelined integer square root, one result bit per register stage.
// ============================================================================
module vau_sqrt (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  vau_pkg::vau_side_t                     in_side,
    input  logic [2*vau_pkg::VAU_SQRT_STEPS-1:0]   radicand,
    output logic                                   out_valid,
    output vau_pkg::vau_side_t                     out_side,
    output logic [vau_pkg::VAU_SQRT_STEPS-1:0]     root
);
    import vau_pkg::*;

    localparam int N  = VAU_SQRT_STEPS;
    localparam int RW = N + 2;

    // Stage inputs.
    wire            v_in    [0:N-1];
    wire vau_side_t side_in [0:N-1];
    wire [2*N-1:0]  x_in    [0:N-1];
    wire [RW-1:0]   rem_in  [0:N-1];
    wire [N-1:0]    root_in [0:N-1];

    // Stage registers.
    logic           v_reg    [0:N-1];
    vau_side_t      side_reg [0:N-1];
    logic [2*N-1:0] x_reg    [0:N-1];
    logic [RW-1:0]  rem_reg  [0:N-1];
    logic [N-1:0]   root_reg [0:N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam int PB = 2 * (N - 1 - k);
        logic [RW+1:0] rem2;
        logic [RW+1:0] trial;
        logic          ge;

        // Chain each stage to the one before it.
        if (k == 0)
        begin : g_first
            assign v_in[k]    = in_valid;
            assign side_in[k] = in_side;
            assign x_in[k]    = radicand;
            assign rem_in[k]  = '0;
            assign root_in[k] = '0;
        end
        else
        begin : g_chain
            assign v_in[k]    = v_reg[k-1];
            assign side_in[k] = side_reg[k-1];
            assign x_in[k]    = x_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
        end

        // Bring down the next bit pair and try the next root bit.
        assign rem2  = {rem_in[k], x_in[k][PB+1:PB]};
        assign trial = {2'b00, root_in[k], 2'b01};
        assign ge    = (rem2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_in[k];
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in[k];
            x_reg[k]    <= x_in[k];
            rem_reg[k]  <= ge ? RW'(rem2 - trial) : RW'(rem2);
            root_reg[k] <= {root_in[k][N-2:0], ge};
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign root      = root_reg[N-1];

endmodule

### src/vau_div.sv
// ============================================================================
// vau_div
// Pipelined restoring divider with three lanes sharing one divisor. Divides
// the magnitudes of the a components, scaled up by the fraction bits, by the
// scalar magnitude or by the vector magnitude; one quotient bit per stage.
// ============================================================================
module vau_div #(
    parameter int FRAC_BITS = vau_pkg::VAU_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  vau_pkg::vau_side_t            in_side,
    input  logic [31:0]                   root,
    output logic                          out_valid,
    output vau_pkg::vau_side_t            out_side,
    output logic [31:0]                   divisor,
    output logic [2:0][32+FRAC_BITS-1:0]  quo
);
    import vau_pkg::*;

    localparam int QW = 32 + FRAC_BITS;

    // ------------------------------------------------------------------
    // Preparation stage: operand magnitudes and divisor selection.
    // ------------------------------------------------------------------
    logic [31:0]      d_next;
    logic [2:0][31:0] na_next;

    always_comb
    begin
        d_next = (in_side.op == OP_DIV_S) ?
                 (in_side.s[31] ? (~in_side.s + 32'd1) : in_side.s) : root;
        if (((in_side.op == OP_DIV_S) || (in_side.op == OP_NORM)) && (d_next == '0))
            d_next = 32'd1;
        na_next[0] = in_side.a_x[31] ? (~in_side.a_x + 32'd1) : in_side.a_x;
        na_next[1] = in_side.a_y[31] ? (~in_side.a_y + 32'd1) : in_side.a_y;
        na_next[2] = in_side.a_z[31] ? (~in_side.a_z + 32'd1) : in_side.a_z;
    end

    logic             pv_reg;
    vau_side_t        pside_reg;
    logic [31:0]      pd_reg;
    logic [2:0][31:0] pna_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pside_reg <= in_side;
        pd_reg    <= d_next;
        pna_reg   <= na_next;
    end

    // ------------------------------------------------------------------
    // Quotient steps.
    // ------------------------------------------------------------------
    wire                   v_in    [0:QW-1];
    wire vau_side_t        side_in [0:QW-1];
    wire [31:0]            d_in    [0:QW-1];
    wire [2:0][31:0]       na_in   [0:QW-1];
    wire [2:0][31:0]       rem_in  [0:QW-1];
    wire [2:0][QW-1:0]     q_in    [0:QW-1];

    logic                  v_reg    [0:QW-1];
    vau_side_t             side_reg [0:QW-1];
    logic [31:0]           d_reg    [0:QW-1];
    logic [2:0][31:0]      na_reg   [0:QW-1];
    logic [2:0][31:0]      rem_reg  [0:QW-1];
    logic [2:0][QW-1:0]    q_reg    [0:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int J = QW - 1 - k;
        logic [2:0]        nbit;
        logic [2:0][31:0]  rem_next;
        logic [2:0][QW-1:0] q_next;
        logic [32:0]       rem2;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign v_in[k]    = pv_reg;
            assign side_in[k] = pside_reg;
            assign d_in[k]    = pd_reg;
            assign na_in[k]   = pna_reg;
            assign rem_in[k]  = '0;
            assign q_in[k]    = '0;
        end
        else
        begin : g_chain
            assign v_in[k]    = v_reg[k-1];
            assign side_in[k] = side_reg[k-1];
            assign d_in[k]    = d_reg[k-1];
            assign na_in[k]   = na_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign q_in[k]    = q_reg[k-1];
        end

        // The low fraction bits of the scaled dividend are zero.
        if (J >= FRAC_BITS)
        begin : g_hi
            assign nbit = {na_in[k][2][J-FRAC_BITS], na_in[k][1][J-FRAC_BITS],
                           na_in[k][0][J-FRAC_BITS]};
        end
        else
        begin : g_lo
            assign nbit = '0;
        end

        // One restoring step in each lane.
        always_comb
        begin
            rem2 = '0;
            ge   = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                rem2 = {rem_in[k][i], nbit[i]};
                ge   = (rem2 >= {1'b0, d_in[k]});
                rem_next[i] = ge ? 32'(rem2 - {1'b0, d_in[k]}) : rem2[31:0];
                q_next[i]   = {q_in[k][i][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_in[k];
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in[k];
            d_reg[k]    <= d_in[k];
            na_reg[k]   <= na_in[k];
            rem_reg[k]  <= rem_next;
            q_reg[k]    <= q_next;
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign divisor   = d_reg[QW-1];
    assign quo       = q_reg[QW-1];

endmodule

### src/vec3_arithmetic_unit_core.sv
// ============================================================================
// vec3_arithmetic_unit_core
// Three-component fixed-point vector unit: add, subtract, scalar operations,
// dot and cross product, magnitude, normalize and compares, fully pipelined.
//
//   Channel   Handshake           Payload     Direction
//   request   start / busy        req         in
//   result    done (strobe)       rsp         out
//
// A transaction is taken in every cycle; busy is always low.
// The path is the same for every opcode: four front stages, 32 square-root
// steps, one divider preparation stage, 32 + FRAC_BITS quotient steps and
// the output register.
// The square-root and divider step chains set the latency.
// Reset clears only the valid bits of the pipeline; done is low after reset.
// The receiver cannot stall, so each result is shown for one cycle.
// ============================================================================
module vec3_arithmetic_unit_core #(
    parameter int FRAC_BITS = vau_pkg::VAU_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  vau_pkg::vau_req_t  req,
    output logic               done,
    output vau_pkg::vau_rsp_t  rsp
);
    import vau_pkg::*;

    localparam int QW = 32 + FRAC_BITS;

    // The pipeline never holds off a request.
    assign busy = 1'b0;

    // Front end.
    logic        fr_valid;
    vau_side_t   fr_side;
    logic [63:0] fr_ssq;

    vau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .req       (req),
        .out_valid (fr_valid),
        .side      (fr_side),
        .ssq       (fr_ssq)
    );

    // Magnitude.
    logic        sq_valid;
    vau_side_t   sq_side;
    logic [31:0] sq_root;

    vau_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .radicand  (fr_ssq),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root      (sq_root)
    );

    // Division.
    logic               dv_valid;
    vau_side_t          dv_side;
    logic [31:0]        dv_divisor;
    logic [2:0][QW-1:0] dv_quo;

    vau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .root      (sq_root),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .divisor   (dv_divisor),
        .quo       (dv_quo)
    );

    // Signed saturation of a quotient magnitude; msb is the error.
    function automatic logic [32:0] sat_quo(input logic [QW-1:0] q, input logic neg);
        logic        big_pos;
        logic        big_neg;
        logic [32:0] res;
        big_pos = (q[QW-1:31] != '0);
        big_neg = (q[QW-1:32] != '0) || (q[31] && (q[30:0] != '0));
        if (neg)
            res = big_neg ? {1'b1, VAU_MIN} : {1'b0, 32'(~q[31:0] + 32'd1)};
        else
            res = big_pos ? {1'b1, VAU_MAX} : {1'b0, q[31:0]};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Output stage: signs, saturation and final result selection.
    // ------------------------------------------------------------------
    logic signed [31:0] fa [0:2];
    logic [32:0]        qs [0:2];
    logic signed [31:0] rv [0:2];
    logic               verr;
    vau_rsp_t           rsp_next;

    always_comb
    begin
        fa[0] = dv_side.a_x;
        fa[1] = dv_side.a_y;
        fa[2] = dv_side.a_z;
        verr  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = sat_quo(dv_quo[i],
                            fa[i][31] ^ ((dv_side.op == OP_DIV_S) & dv_side.s[31]));
            // A zero divisor gives the limit that matches the dividend sign, or zero for a zero dividend.
            if ((dv_side.op == OP_DIV_S) && dv_side.early.error_out)
                rv[i] = fa[i][31] ? VAU_MIN : ((fa[i] != '0) ? VAU_MAX : '0);
            else
                rv[i] = qs[i][31:0];
            verr = verr | qs[i][32];
        end

        rsp_next = dv_side.early;
        case (dv_side.op)
            OP_DIV_S, OP_NORM:
            begin
                rsp_next.r_x       = rv[0];
                rsp_next.r_y       = rv[1];
                rsp_next.r_z       = rv[2];
                rsp_next.error_out = dv_side.early.error_out | verr;
            end
            OP_MAG:
            begin
                rsp_next.scalar_out = dv_divisor[31] ? VAU_MAX : dv_divisor;
                rsp_next.error_out  = dv_divisor[31];
            end
            default:
            begin
            end
        endcase
    end

    logic     done_reg;
    vau_rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Compares never saturate, so a true flag never comes with an error.
    a_flag_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.flag_out |-> !rsp.error_out)
        else $error("compare result carries an error");

    // A compare transaction with a true flag leaves vector and scalar results at zero.
    a_flag_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.flag_out |->
        (rsp.r_x == '0) && (rsp.r_y == '0) && (rsp.r_z == '0) && (rsp.scalar_out == '0))
        else $error("compare result has nonzero data");

    // Scalar results and vector results never appear in the same transaction.
    a_scalar_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.scalar_out != '0) |->
        (rsp.r_x == '0) && (rsp.r_y == '0) && (rsp.r_z == '0))
        else $error("scalar result mixed with vector result");

endmodule

### tb/vau_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// vau_checker
// Watches the request and result channels of the vector unit, predicts each
// result from the accepted request and compares it field by field.
// ============================================================================
module vau_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  vau_pkg::vau_req_t req,
    input  logic              done,
    input  vau_pkg::vau_rsp_t rsp,
    output int                fails,
    output int                pending
);
    import vau_pkg::*;

    localparam int FB = VAU_FRAC_BITS;

    typedef logic signed [127:0] wide_t;

    vau_rsp_t expected_rsps[$];
    int       mismatches;

    // Clamp a wide value into 32 bits and note any saturation.
    function automatic logic signed [31:0] clamp32(input wide_t x, inout bit err);
        if (x > wide_t'(VAU_MAX)) begin
            err = 1'b1;
            return VAU_MAX;
        end
        if (x < wide_t'(VAU_MIN)) begin
            err = 1'b1;
            return VAU_MIN;
        end
        return x[31:0];
    endfunction

    // Round an exact product sum to nearest, ties toward plus infinity.
    function automatic wide_t round_q(input wide_t x);
        return (x + (wide_t'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic wide_t sum_sq(input wide_t x, input wide_t y, input wide_t z);
        return x * x + y * y + z * z;
    endfunction

    // Floor square root, one result bit per pass.
    function automatic wide_t floor_sqrt(input wide_t v);
        wide_t x;
        wide_t res;
        wide_t b;
        x   = v;
        res = 0;
        b   = wide_t'(1) <<< 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    // Work out the result of one request.
    function automatic vau_rsp_t vector_result(input vau_req_t q);
        vau_rsp_t r;
        wide_t    a[3];
        wide_t    b[3];
        wide_t    s;
        wide_t    m;
        logic signed [31:0] rv[3];
        bit       err;
        int       j;
        int       k;
        r    = '0;
        err  = 1'b0;
        rv   = '{32'sd0, 32'sd0, 32'sd0};
        a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
        b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
        s    = q.scalar_in;
        case (q.req_type)
            OP_ADD:   for (int i = 0; i < 3; i++) rv[i] = clamp32(a[i] + b[i], err);
            OP_SUB:   for (int i = 0; i < 3; i++) rv[i] = clamp32(a[i] - b[i], err);
            OP_ADD_S: for (int i = 0; i < 3; i++) rv[i] = clamp32(a[i] + s, err);
            OP_SUB_S: for (int i = 0; i < 3; i++) rv[i] = clamp32(a[i] - s, err);
            OP_MUL_S: for (int i = 0; i < 3; i++) rv[i] = clamp32(round_q(a[i] * s), err);
            OP_DIV_S: begin
                if (s == 0) begin
                    // A zero divisor pushes each nonzero component to its rail.
                    err = 1'b1;
                    for (int i = 0; i < 3; i++)
                        rv[i] = (a[i] > 0) ? VAU_MAX : ((a[i] < 0) ? VAU_MIN : 32'sd0);
                end else begin
                    for (int i = 0; i < 3; i++)
                        rv[i] = clamp32((a[i] <<< FB) / s, err);
                end
            end
            OP_DOT: r.scalar_out = clamp32(round_q(a[0] * b[0] + a[1] * b[1]
                                                   + a[2] * b[2]), err);
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    rv[i] = clamp32(round_q(a[j] * b[k] - a[k] * b[j]), err);
                end
            end
            OP_MAG: r.scalar_out = clamp32(floor_sqrt(sum_sq(a[0], a[1], a[2])), err);
            OP_NORM: begin
                // A zero vector divides by one and stays zero.
                m = floor_sqrt(sum_sq(a[0], a[1], a[2]));
                if (m == 0)
                    m = 1;
                for (int i = 0; i < 3; i++)
                    rv[i] = clamp32((a[i] <<< FB) / m, err);
            end
            OP_EQ: r.flag_out = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            OP_GT: r.flag_out = sum_sq(a[0], a[1], a[2]) > sum_sq(b[0], b[1], b[2]);
            OP_LT: r.flag_out = sum_sq(a[0], a[1], a[2]) < sum_sq(b[0], b[1], b[2]);
            default: ;
        endcase
        r.r_x       = rv[0];
        r.r_y       = rv[1];
        r.r_z       = rv[2];
        r.error_out = err;
        return r;
    endfunction

    assign pending = expected_rsps.size();
    assign fails   = mismatches;

    // Predict on each accepted request, compare on each result strobe.
    always @(posedge clk or negedge rst_n) begin
        vau_rsp_t want;
        if (!rst_n) begin
            mismatches <= 0;
        end else begin
            if (start && !busy)
                expected_rsps.push_back(vector_result(req));
            if (done) begin
                if (expected_rsps.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: unexpected result transaction %h", rsp);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp.r_x !== want.r_x || rsp.r_y !== want.r_y
                        || rsp.r_z !== want.r_z || rsp.scalar_out !== want.scalar_out
                        || rsp.flag_out !== want.flag_out
                        || rsp.error_out !== want.error_out) begin
                        if (mismatches < 10)
                            $display("ERROR: result mismatch exp %h got %h", want, rsp);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/tb_vec3_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_vec3_arithmetic_unit_core
// Drives directed and random vector requests into the unit with varying gaps
// and reports the verdict from the checker's mismatch and pending counts.
// ============================================================================
module tb_vec3_arithmetic_unit_core;
    import vau_pkg::*;

    localparam int LATENCY   = 70 + VAU_FRAC_BITS;
    localparam int MAX_CYCLE = 200000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    vau_req_t req;
    vau_rsp_t rsp;
    int       fails;
    int       pending;
    int       cycle_count;
    int       idle_pct;

    vec3_arithmetic_unit_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    vau_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .fails   (fails),
        .pending (pending)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLE) begin
                $display("tb_vec3_arithmetic_unit_core NOT OK");
                $finish;
            end
        end
    end

    // Operand picker mixing full-range, small, mid-size and edge values.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(2097151)) - 32'sd1048576;
            3: return $signed($urandom_range(33554431)) - 32'sd16777216;
            default: begin
                case ($urandom_range(6))
                    0: return VAU_MAX;
                    1: return VAU_MIN;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    5: return 32'sh0001_0000;
                    default: return -32'sh0001_0000;
                endcase
            end
        endcase
    endfunction

    // Send one transaction, with a random idle stretch ahead of it.
    task automatic send(input vau_req_t item);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        forever begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
            if (taken)
                break;
        end
    endtask

    task automatic send_op(input logic [3:0] op, input logic signed [31:0] av,
                           input logic signed [31:0] bv, input logic signed [31:0] sv);
        vau_req_t item;
        item = '{op, av, -av, av, bv, bv, -bv, sv};
        send(item);
    endtask

    initial begin
        vau_req_t item;
        int       waited;
        start    = 1'b0;
        req      = '0;
        rst_n    = 1'b0;
        idle_pct = 7;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every opcode at the rails, plus the special cases.
        for (int op = 0; op <= 12; op++)
            send_op(op[3:0], VAU_MAX, VAU_MIN, VAU_MIN);
        send_op(OP_DIV_S, 32'sh0003_0000, 32'sd0, 32'sd0);       // zero divisor
        send_op(OP_DIV_S, 32'sd0, 32'sd0, 32'sd0);               // zero over zero
        send_op(OP_DIV_S, VAU_MIN, 32'sd0, -32'sd1);             // divide overflow
        send_op(OP_NORM, 32'sd0, 32'sd0, 32'sd0);                // zero vector
        send_op(OP_NORM, 32'sh0002_0000, 32'sd0, 32'sd0);
        send_op(OP_EQ, 32'sh1234_5678, 32'sh1234_5678, 32'sd0);  // not equal, equal below
        item = '{OP_EQ, 32'sd5, 32'sd6, 32'sd7, 32'sd5, 32'sd6, 32'sd7, 32'sd0};
        send(item);
        send_op(OP_MUL_S, 32'sd1, 32'sd0, 32'sh0000_8000);       // rounding tie
        send_op(OP_MUL_S, -32'sd1, 32'sd0, 32'sh0000_8000);
        send_op(OP_DOT, VAU_MIN, VAU_MIN, 32'sd0);
        send_op(4'd13, VAU_MAX, VAU_MAX, VAU_MAX);
        send_op(4'd15, -32'sd1, -32'sd1, -32'sd1);

        // Random: three idle phases.
        for (int n = 0; n < 600; n++) begin
            if (n == 200)
                idle_pct = 46;
            else if (n == 400)
                idle_pct = 0;
            item.req_type  = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13))
                                                       : 4'($urandom_range(12));
            item.a_x       = pick_word();
            item.a_y       = pick_word();
            item.a_z       = pick_word();
            item.b_x       = pick_word();
            item.b_y       = pick_word();
            item.b_z       = pick_word();
            item.scalar_in = pick_word();
            if (item.req_type == OP_EQ && $urandom_range(1))
                {item.b_x, item.b_y, item.b_z} = {item.a_x, item.a_y, item.a_z};
            send(item);
        end
        start <= 1'b0;

        // Drain outstanding results, then allow trailing strobes.
        waited = 0;
        while (pending != 0 && waited < 20 * LATENCY) begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("tb_vec3_arithmetic_unit_core OK");
        else
            $display("tb_vec3_arithmetic_unit_core NOT OK");
        $finish;
    end

endmodule

### filelist.f
src/vau_pkg.sv
src/vau_front.sv
src/vau_sqrt.sv
src/vau_div.sv
src/vec3_arithmetic_unit_core.sv
tb/vau_checker.sv
tb/tb_vec3_arithmetic_unit_core.sv
